/* sv/cosine_similarity_unit_assert.svh */
// Assertion macros for the checker file of the cosine similarity unit.
`ifndef COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cosine_similarity_unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cosine_similarity_unit assertion failed");

`endif

/* sv/csu_pkg.sv */
// Shared constants, width functions and status types of the cosine similarity unit.
package csu_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int MAX_LEN_DEF    = 1024;
    localparam int FRAC_BITS      = 15;
    localparam int SIM_WIDTH      = FRAC_BITS + 1;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    function automatic int dot_width(input int elem_w, input int max_len);
        return 2 * elem_w + $clog2(max_len);
    endfunction

    function automatic int norm_width(input int elem_w, input int max_len);
        return 2 * elem_w - 1 + $clog2(max_len);
    endfunction

    typedef struct packed {
        logic       push;
        logic [1:0] pending;
    } front_stat_t;

    typedef struct packed {
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } fifo_stat_t;

endpackage

/* sv/csu_front.sv */
// Front end: element products and saturating dot and norm accumulators.
module csu_front #(
    parameter int ELEM_WIDTH = csu_pkg::ELEM_WIDTH_DEF,
    parameter int MAX_LEN    = csu_pkg::MAX_LEN_DEF,
    localparam int DW        = csu_pkg::dot_width(ELEM_WIDTH, MAX_LEN),
    localparam int NW        = csu_pkg::norm_width(ELEM_WIDTH, MAX_LEN)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic signed [ELEM_WIDTH-1:0] elem_a,
    input  logic signed [ELEM_WIDTH-1:0] elem_b,
    input  logic                         last,
    output csu_pkg::front_stat_t         stat,
    output logic [DW+2*NW-1:0]           sums
);

    localparam int PW = 2 * ELEM_WIDTH;

    logic                         s1_valid_reg;
    logic                         s1_last_reg;
    logic signed [ELEM_WIDTH-1:0] s1_a_reg;
    logic signed [ELEM_WIDTH-1:0] s1_b_reg;

    logic                  s2_valid_reg;
    logic                  s2_last_reg;
    logic signed [PW-1:0]  s2_ab_reg;
    logic [PW-1:0]         s2_aa_reg;
    logic [PW-1:0]         s2_bb_reg;

    logic signed [DW-1:0]  dot_reg;
    logic [NW-1:0]         na_reg;
    logic [NW-1:0]         nb_reg;

    logic signed [PW-1:0]  ab_prod;
    logic signed [PW-1:0]  aa_prod;
    logic signed [PW-1:0]  bb_prod;

    logic [DW:0]   dot_full;
    logic [NW:0]   na_full;
    logic [NW:0]   nb_full;
    logic [DW-1:0] dot_sat;
    logic [NW-1:0] na_sat;
    logic [NW-1:0] nb_sat;

    assign ab_prod = s1_a_reg * s1_b_reg;
    assign aa_prod = s1_a_reg * s1_a_reg;
    assign bb_prod = s1_b_reg * s1_b_reg;

    assign dot_full = {dot_reg[DW-1], dot_reg}
                    + {{(DW+1-PW){s2_ab_reg[PW-1]}}, s2_ab_reg};
    assign na_full  = {1'b0, na_reg} + {{(NW+1-PW){1'b0}}, s2_aa_reg};
    assign nb_full  = {1'b0, nb_reg} + {{(NW+1-PW){1'b0}}, s2_bb_reg};

    always_comb
    begin
        if (dot_full[DW] != dot_full[DW-1])
        begin
            dot_sat = {dot_full[DW], {(DW-1){~dot_full[DW]}}};
        end
        else
        begin
            dot_sat = dot_full[DW-1:0];
        end
        na_sat = na_full[NW] ? {NW{1'b1}} : na_full[NW-1:0];
        nb_sat = nb_full[NW] ? {NW{1'b1}} : nb_full[NW-1:0];
    end

    assign stat.push    = s2_valid_reg & s2_last_reg;
    assign stat.pending = {1'b0, s1_valid_reg & s1_last_reg}
                        + {1'b0, s2_valid_reg & s2_last_reg};
    assign sums         = {dot_sat, na_sat, nb_sat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            dot_reg      <= '0;
            na_reg       <= '0;
            nb_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    dot_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                end
                else
                begin
                    dot_reg <= dot_sat;
                    na_reg  <= na_sat;
                    nb_reg  <= nb_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_a_reg    <= elem_a;
            s1_b_reg    <= elem_b;
            s1_last_reg <= last;
        end
        if (s1_valid_reg)
        begin
            s2_ab_reg   <= ab_prod;
            s2_aa_reg   <= aa_prod;
            s2_bb_reg   <= bb_prod;
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

/* sv/csu_fifo.sv */
// Short queue of finished accumulator sets between front and back end.
module csu_fifo #(
    parameter int WIDTH = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wdata,
    input  logic                pop,
    output logic [WIDTH-1:0]    rdata,
    output csu_pkg::fifo_stat_t stat
);

    logic [WIDTH-1:0]                  mem_reg [csu_pkg::FIFO_DEPTH];
    logic [csu_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [csu_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [csu_pkg::FIFO_CNT_W-1:0]    count_reg;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + csu_pkg::FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + csu_pkg::FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + csu_pkg::FIFO_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - csu_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/csu_back.sv */
// Back end: serial norm product, digit square root, restoring divide, result register.
module csu_back #(
    parameter int ELEM_WIDTH = csu_pkg::ELEM_WIDTH_DEF,
    parameter int MAX_LEN    = csu_pkg::MAX_LEN_DEF,
    localparam int DW        = csu_pkg::dot_width(ELEM_WIDTH, MAX_LEN),
    localparam int NW        = csu_pkg::norm_width(ELEM_WIDTH, MAX_LEN)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csu_pkg::fifo_stat_t                 qstat,
    input  logic [DW+2*NW-1:0]                  qdata,
    output logic                                pop,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [csu_pkg::SIM_WIDTH-1:0] similarity,
    output logic                                zero_norm
);

    localparam int CW = $clog2(NW);
    localparam int FB = csu_pkg::FRAC_BITS;
    localparam int SW = csu_pkg::SIM_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic            neg_reg;
    logic            zero_reg;
    logic [DW-1:0]   mag_reg;
    logic [NW-1:0]   mcand_reg;
    logic [2*NW-1:0] work_reg;
    logic [NW+1:0]   rem_reg;
    logic [NW-1:0]   root_reg;
    logic [FB-1:0]   quo_reg;
    logic            out_valid_reg;
    logic [SW-1:0]   out_sim_reg;
    logic            out_zero_reg;

    logic [DW-1:0]   q_dot;
    logic [NW-1:0]   q_na;
    logic [NW-1:0]   q_nb;
    logic [NW:0]     mul_sum;
    logic [NW+1:0]   sq_rem;
    logic [NW+1:0]   sq_trial;
    logic            sq_ge;
    logic [NW+1:0]   dv_rem;
    logic [NW+1:0]   dv_den;
    logic            dv_ge;
    logic            out_free;
    logic [SW-1:0]   sim_mag;

    assign q_dot = qdata[DW+2*NW-1:2*NW];
    assign q_na  = qdata[2*NW-1:NW];
    assign q_nb  = qdata[NW-1:0];

    assign mul_sum  = {1'b0, work_reg[2*NW-1:NW]} + (work_reg[0] ? {1'b0, mcand_reg} : '0);
    assign sq_rem   = {rem_reg[NW-1:0], work_reg[2*NW-1:2*NW-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = (sq_rem >= sq_trial);
    assign dv_rem   = {rem_reg[NW:0], 1'b0};
    assign dv_den   = {2'b00, root_reg};
    assign dv_ge    = (dv_rem >= dv_den);
    assign out_free = !out_valid_reg || !result_stall;
    assign sim_mag  = {1'b0, quo_reg};

    assign pop          = (state_reg == ST_IDLE) && !qstat.empty;
    assign result_valid = out_valid_reg;
    assign similarity   = out_sim_reg;
    assign zero_norm    = out_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            mag_reg       <= '0;
            mcand_reg     <= '0;
            work_reg      <= '0;
            rem_reg       <= '0;
            root_reg      <= '0;
            quo_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_sim_reg   <= '0;
            out_zero_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !result_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        neg_reg   <= q_dot[DW-1];
                        mag_reg   <= q_dot[DW-1] ? (~q_dot + DW'(1)) : q_dot;
                        mcand_reg <= q_na;
                        work_reg  <= {{NW{1'b0}}, q_nb};
                        cnt_reg   <= CW'(NW - 1);
                        if (q_na == '0 || q_nb == '0)
                        begin
                            zero_reg  <= 1'b1;
                            quo_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            zero_reg  <= 1'b0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    work_reg <= {mul_sum, work_reg[NW-1:1]};
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= CW'(NW - 1);
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                ST_SQRT:
                begin
                    rem_reg  <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
                    root_reg <= {root_reg[NW-2:0], sq_ge};
                    work_reg <= {work_reg[2*NW-3:0], 2'b00};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                ST_CMP:
                begin
                    // quotient reaches 2^FB exactly when mag >= root
                    if (mag_reg >= {1'b0, root_reg})
                    begin
                        quo_reg   <= '1;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        rem_reg   <= {2'b00, mag_reg[NW-1:0]};
                        quo_reg   <= '0;
                        cnt_reg   <= CW'(FB - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= dv_ge ? (dv_rem - dv_den) : dv_rem;
                    quo_reg <= {quo_reg[FB-2:0], dv_ge};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sim_reg   <= neg_reg ? (~sim_mag + SW'(1)) : sim_mag;
                        out_zero_reg  <= zero_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/cosine_similarity_unit.sv */
// Cosine similarity unit top level: front end, accumulator queue and back end.
// Element pairs enter at one per cycle while item_stall is low and are folded
// into saturating dot and norm accumulators; a pair marked last closes the
// vector and its sums go into a four-entry queue. For each vector the back end
// takes the sums, forms the norm product bit-serially over NW bits (NW =
// 2*ELEM_WIDTH-1+clog2(MAX_LEN)), takes the square root at one result bit
// per step, makes one compare, runs 15 restoring divide steps and loads the
// result register. A zero norm goes straight to the result register and a
// quotient that clamps skips the divide. Long vectors therefore stream at
// one pair per cycle; short ones are limited by the back end, and item_stall
// rises once queued plus in-flight vectors reach four.
module cosine_similarity_unit #(
    parameter int ELEM_WIDTH = csu_pkg::ELEM_WIDTH_DEF,
    parameter int MAX_LEN    = csu_pkg::MAX_LEN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic signed [ELEM_WIDTH-1:0]         elem_a,
    input  logic signed [ELEM_WIDTH-1:0]         elem_b,
    input  logic                                 last,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [csu_pkg::SIM_WIDTH-1:0] similarity,
    output logic                                 zero_norm
);

    localparam int DW  = csu_pkg::dot_width(ELEM_WIDTH, MAX_LEN);
    localparam int NW  = csu_pkg::norm_width(ELEM_WIDTH, MAX_LEN);
    localparam int QW  = DW + 2 * NW;
    localparam int OCW = csu_pkg::FIFO_CNT_W + 1;

    csu_pkg::front_stat_t front_stat;
    csu_pkg::fifo_stat_t  fifo_stat;
    logic [QW-1:0]        sums;
    logic [QW-1:0]        qdata;
    logic                 pop;
    logic                 accept;
    logic [OCW-1:0]       occupancy;

    assign occupancy  = OCW'(fifo_stat.count) + OCW'(front_stat.pending);
    assign item_stall = (occupancy >= OCW'(csu_pkg::FIFO_DEPTH));
    assign accept     = item_valid && !item_stall;

    csu_front #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .MAX_LEN    (MAX_LEN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .elem_a (elem_a),
        .elem_b (elem_b),
        .last   (last),
        .stat   (front_stat),
        .sums   (sums)
    );

    csu_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_stat.push),
        .wdata (sums),
        .pop   (pop),
        .rdata (qdata),
        .stat  (fifo_stat)
    );

    csu_back #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .MAX_LEN    (MAX_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (fifo_stat),
        .qdata        (qdata),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .similarity   (similarity),
        .zero_norm    (zero_norm)
    );

endmodule

/* sv/csu_checker.sv */
// Port-level checker for the cosine similarity unit and its bind.
`include "cosine_similarity_unit_assert.svh"

module csu_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic signed [csu_pkg::SIM_WIDTH-1:0] similarity,
    input logic                                 zero_norm
);

    `CSU_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid)
    `CSU_ASSERT_NEXT(a_payload_held, clk, rst_n, result_valid && result_stall, $stable(similarity) && $stable(zero_norm))
    `CSU_ASSERT_SAME(a_zero_norm_sim, clk, rst_n, result_valid && zero_norm, similarity == '0)
    `CSU_ASSERT_SAME(a_sim_clamped, clk, rst_n, result_valid, similarity != {1'b1, {(csu_pkg::SIM_WIDTH-1){1'b0}}})

endmodule

bind cosine_similarity_unit csu_checker u_csu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .similarity   (similarity),
    .zero_norm    (zero_norm)
);
